@@ src/ata_psr_pkg.sv @@
// package for the ata pio sector read sequencer
// types, codes and constants shared by the controller, datapath and top level
// no dependencies
`default_nettype none
package ata_psr_pkg;

    localparam int SECTOR_WORDS     = 256;
    localparam int BUSY_POLL_LIMIT  = 500000;
    localparam int READY_POLL_LIMIT = 1000;
    localparam int RETRY_LIMIT      = 255;

    localparam int POLL_W  = 20;
    localparam int WORD_W  = 9;
    localparam int RETRY_W = 8;
    localparam int LBA_W   = 28;
    localparam int GEOM_W  = 13;
    localparam int DCNT_W  = 5;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [2:0] REG_DATA       = 3'd0;
    localparam logic [2:0] REG_COUNT      = 3'd2;
    localparam logic [2:0] REG_SECTOR     = 3'd3;
    localparam logic [2:0] REG_CYL_LO     = 3'd4;
    localparam logic [2:0] REG_CYL_HI     = 3'd5;
    localparam logic [2:0] REG_DRIVE_HEAD = 3'd6;
    localparam logic [2:0] REG_STATUS_CMD = 3'd7;

    localparam logic [2:0] CC_OK            = 3'd0;
    localparam logic [2:0] CC_READY_TIMEOUT = 3'd1;
    localparam logic [2:0] CC_BUSY_TIMEOUT  = 3'd2;
    localparam logic [2:0] CC_DEVICE_ERROR  = 3'd3;
    localparam logic [2:0] CC_OVERRUN       = 3'd4;
    localparam logic [2:0] CC_RETRIES       = 3'd5;

    localparam logic [1:0] CFG_LBA_MODE     = 2'd0;
    localparam logic [1:0] CFG_DRIVE_SELECT = 2'd1;
    localparam logic [1:0] CFG_HEAD_COUNT   = 2'd2;
    localparam logic [1:0] CFG_SPT          = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [27:0] block_address;
        logic [7:0]  command_code;
        logic        status_busy;
        logic        status_ready;
        logic        status_drq;
        logic        status_error;
        logic [15:0] read_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  register_offset;
        logic [15:0] write_value;
        logic [2:0]  completion_code;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_READY, PH_FIRST, PH_BUSY, PH_DATA, PH_DSTAT
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_DIV1_START, ST_DIV1_WAIT, ST_DIV2_START, ST_DIV2_WAIT,
        ST_SEC, ST_CYLL, ST_CYLH, ST_DH, ST_CNT, ST_CMD, ST_REQ_STAT, ST_REQ_DATA,
        ST_WORD, ST_DONE
    } seq_t;

    typedef enum logic [3:0] {
        EM_NONE, EM_SEC, EM_CYLL, EM_CYLH, EM_DH, EM_CNT, EM_CMD, EM_REQ_STAT,
        EM_REQ_DATA, EM_WORD, EM_DONE
    } emit_t;

    typedef struct packed {
        logic       take;
        logic       load_start;
        logic       load_lba;
        logic       div_start;
        logic       div_second;
        logic       div1_latch;
        logic       div2_latch;
        logic       clr_poll;
        logic       inc_poll;
        logic       clr_word;
        logic       inc_word;
        logic       inc_retry;
        logic       emit_en;
        emit_t      emit;
        logic [2:0] code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       busy;
        logic       ready;
        logic       drq;
        logic       err;
        logic       lba_mode;
        logic       geom_zero;
        logic       div_done;
        logic       poll_gt_ready;
        logic       poll_gt_busy;
        logic       word_full;
        logic       word_next_full;
        logic       word_over;
        logic       retry_next_full;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ src/ata_psr_top.sv @@
// ata pio sector read sequencer: one word in, up to six words out, one at a time
// a decode state comes first, then the result words, each emitted only while the output is free
// a chs start with nonzero geometry adds two divider passes before the first result
// input: the next word is stalled until the sequencing state machine is back in idle
// reset: asynchronous active low, clears configuration, phase, counters and output valid
// top level; depends on ata_psr_pkg, ata_psr_ctrl, ata_psr_dp
`default_nettype none
module ata_pio_sector_read_sequencer_top #(
    parameter int SECTOR_WORDS     = ata_psr_pkg::SECTOR_WORDS,
    parameter int BUSY_POLL_LIMIT  = ata_psr_pkg::BUSY_POLL_LIMIT,
    parameter int READY_POLL_LIMIT = ata_psr_pkg::READY_POLL_LIMIT,
    parameter int RETRY_LIMIT      = ata_psr_pkg::RETRY_LIMIT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire ata_psr_pkg::in_item_t in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output ata_psr_pkg::out_item_t     out_item
);
    import ata_psr_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ata_psr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ata_psr_dp #(
        .SECTOR_WORDS     (SECTOR_WORDS),
        .BUSY_POLL_LIMIT  (BUSY_POLL_LIMIT),
        .READY_POLL_LIMIT (READY_POLL_LIMIT),
        .RETRY_LIMIT      (RETRY_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule
`default_nettype wire

@@ src/ata_psr_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// used for the chs conversion; depends on ata_psr_pkg
`default_nettype none
module ata_psr_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [27:0] dividend,
    input  wire logic [12:0] divisor,
    output logic      [27:0] quotient,
    output logic      [12:0] remainder,
    output logic             done
);
    import ata_psr_pkg::*;

    logic [LBA_W-1:0]  quo_reg;
    logic [GEOM_W-1:0] rem_reg;
    logic [GEOM_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [GEOM_W:0]   trial;
    logic [GEOM_W:0]   diff;
    logic              ge;
    logic [GEOM_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[LBA_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[GEOM_W-1:0] : trial[GEOM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(LBA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[LBA_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;
endmodule
`default_nettype wire

@@ src/ata_psr_dp.sv @@
// datapath: configuration, item and address registers, counters, divider, output register
// depends on ata_psr_pkg and ata_psr_div
`default_nettype none
module ata_psr_dp #(
    parameter int SECTOR_WORDS     = ata_psr_pkg::SECTOR_WORDS,
    parameter int BUSY_POLL_LIMIT  = ata_psr_pkg::BUSY_POLL_LIMIT,
    parameter int READY_POLL_LIMIT = ata_psr_pkg::READY_POLL_LIMIT,
    parameter int RETRY_LIMIT      = ata_psr_pkg::RETRY_LIMIT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_data,
    input  wire ata_psr_pkg::in_item_t  in_item,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output ata_psr_pkg::out_item_t      out_item,
    input  wire ata_psr_pkg::ctrl_cmd_t cmd,
    output ata_psr_pkg::dp_stat_t       stat
);
    import ata_psr_pkg::*;

    logic               lba_mode_reg;
    logic               drive_select_reg;
    logic [4:0]         head_count_reg;
    logic [7:0]         spt_reg;
    in_item_t           item_reg;
    logic [7:0]         held_cmd_reg;
    logic [POLL_W-1:0]  poll_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [RETRY_W-1:0] retry_reg;
    logic [3:0]         head_latch_reg;
    logic [7:0]         sec_reg;
    logic [15:0]        cyl_reg;
    logic [GEOM_W-1:0]  rem1_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    out_item_t          out_next;
    logic [GEOM_W-1:0]  geom_prod;
    logic [LBA_W-1:0]   div_dividend;
    logic [GEOM_W-1:0]  div_divisor;
    logic [LBA_W-1:0]   div_quo;
    logic [GEOM_W-1:0]  div_rem;
    logic               div_done;
    logic [RETRY_W:0]   retry_inc;
    logic [WORD_W:0]    word_inc;

    assign geom_prod    = GEOM_W'(head_count_reg * spt_reg);
    assign div_dividend = cmd.div_second ? LBA_W'(rem1_reg) : item_reg.block_address;
    assign div_divisor  = cmd.div_second ? GEOM_W'(spt_reg) : geom_prod;

    ata_psr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_mode_reg     <= 1'b0;
            drive_select_reg <= 1'b0;
            head_count_reg   <= '0;
            spt_reg          <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LBA_MODE:     lba_mode_reg     <= cfg_data[0];
                CFG_DRIVE_SELECT: drive_select_reg <= cfg_data[0];
                CFG_HEAD_COUNT:   head_count_reg   <= cfg_data[4:0];
                CFG_SPT:          spt_reg          <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cmd_reg   <= '0;
            poll_reg       <= '0;
            word_reg       <= '0;
            retry_reg      <= '0;
            head_latch_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                held_cmd_reg <= item_reg.command_code;
            end
            if (cmd.load_start || cmd.clr_poll)
                poll_reg <= '0;
            else if (cmd.inc_poll)
                poll_reg <= poll_reg + 1'b1;
            if (cmd.load_start || cmd.clr_word)
                word_reg <= '0;
            else if (cmd.inc_word)
                word_reg <= word_reg + 1'b1;
            if (cmd.load_start)
                retry_reg <= '0;
            else if (cmd.inc_retry)
                retry_reg <= retry_reg + 1'b1;
            if (cmd.load_lba)
                head_latch_reg <= item_reg.block_address[27:24];
            else if (cmd.div2_latch)
                head_latch_reg <= div_quo[3:0];
            if (cmd.emit_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            item_reg <= in_item;
        if (cmd.load_lba)
        begin
            sec_reg <= item_reg.block_address[7:0];
            cyl_reg <= item_reg.block_address[23:8];
        end
        if (cmd.div1_latch)
        begin
            cyl_reg  <= div_quo[15:0];
            rem1_reg <= div_rem;
        end
        if (cmd.div2_latch)
            sec_reg <= div_rem[7:0] + 8'd1;
        if (cmd.emit_en)
            out_reg <= out_next;
    end

    always_comb
    begin
        out_next = '0;
        case (cmd.emit)
            EM_SEC:
            begin
                out_next.result_kind     = KIND_WRITE;
                out_next.register_offset = REG_SECTOR;
                out_next.write_value     = {8'd0, sec_reg};
            end
            EM_CYLL:
            begin
                out_next.result_kind     = KIND_WRITE;
                out_next.register_offset = REG_CYL_LO;
                out_next.write_value     = {8'd0, cyl_reg[7:0]};
            end
            EM_CYLH:
            begin
                out_next.result_kind     = KIND_WRITE;
                out_next.register_offset = REG_CYL_HI;
                out_next.write_value     = {8'd0, cyl_reg[15:8]};
            end
            EM_DH:
            begin
                out_next.result_kind     = KIND_WRITE;
                out_next.register_offset = REG_DRIVE_HEAD;
                out_next.write_value     = {8'd0, 1'b1, lba_mode_reg, 1'b1, drive_select_reg,
                                            head_latch_reg};
            end
            EM_CNT:
            begin
                out_next.result_kind     = KIND_WRITE;
                out_next.register_offset = REG_COUNT;
                out_next.write_value     = 16'd1;
            end
            EM_CMD:
            begin
                out_next.result_kind     = KIND_WRITE;
                out_next.register_offset = REG_STATUS_CMD;
                out_next.write_value     = {8'd0, held_cmd_reg};
            end
            EM_REQ_STAT:
            begin
                out_next.result_kind     = KIND_READ;
                out_next.register_offset = REG_STATUS_CMD;
                out_next.last_of_run     = 1'b1;
            end
            EM_REQ_DATA:
            begin
                out_next.result_kind     = KIND_READ;
                out_next.register_offset = REG_DATA;
                out_next.last_of_run     = 1'b1;
            end
            EM_WORD:
            begin
                out_next.result_kind     = KIND_WORD;
                out_next.write_value     = item_reg.read_word;
            end
            EM_DONE:
            begin
                out_next.result_kind     = KIND_DONE;
                out_next.completion_code = cmd.code;
                out_next.last_of_run     = 1'b1;
            end
            default: ;
        endcase
    end

    assign retry_inc = {1'b0, retry_reg} + 1'b1;
    assign word_inc  = {1'b0, word_reg} + 1'b1;

    always_comb
    begin
        stat.opcode          = item_reg.opcode;
        stat.busy            = item_reg.status_busy;
        stat.ready           = item_reg.status_ready;
        stat.drq             = item_reg.status_drq;
        stat.err             = item_reg.status_error;
        stat.lba_mode        = lba_mode_reg;
        stat.geom_zero       = (head_count_reg == '0) || (spt_reg == '0);
        stat.div_done        = div_done;
        stat.poll_gt_ready   = poll_reg > POLL_W'(READY_POLL_LIMIT);
        stat.poll_gt_busy    = poll_reg > POLL_W'(BUSY_POLL_LIMIT);
        stat.word_full       = word_reg >= WORD_W'(SECTOR_WORDS);
        stat.word_next_full  = word_inc >= (WORD_W + 1)'(SECTOR_WORDS);
        stat.word_over       = word_inc > (WORD_W + 1)'(SECTOR_WORDS);
        stat.retry_next_full = retry_inc >= (RETRY_W + 1)'(RETRY_LIMIT);
        stat.out_free        = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
endmodule
`default_nettype wire

@@ src/ata_psr_ctrl.sv @@
// controller: sequencing state machine and protocol phase
// drives datapath commands from datapath status; depends on ata_psr_pkg
`default_nettype none
module ata_psr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire ata_psr_pkg::dp_stat_t stat,
    output ata_psr_pkg::ctrl_cmd_t     cmd
);
    import ata_psr_pkg::*;

    seq_t       state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [2:0] code_reg, code_next;

    logic       dec_inc_poll, dec_clr_poll, dec_inc_word, dec_clr_word, dec_inc_retry;
    logic       dec_load_start, dec_load_lba;
    logic       ab_word_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            code_reg  <= CC_OK;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            code_reg  <= code_next;
        end
    end

    // next state, phase and decode actions
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        code_next      = code_reg;
        dec_inc_poll   = 1'b0;
        dec_clr_poll   = 1'b0;
        dec_inc_word   = 1'b0;
        dec_clr_word   = 1'b0;
        dec_inc_retry  = 1'b0;
        dec_load_start = 1'b0;
        dec_load_lba   = 1'b0;
        ab_word_full   = stat.word_full;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECODE;
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                case (stat.opcode)
                    OP_START:
                        if (phase_reg == PH_IDLE)
                        begin
                            dec_load_start = 1'b1;
                            dec_load_lba   = stat.lba_mode;
                            phase_next     = PH_READY;
                            if (stat.lba_mode)
                                state_next = ST_SEC;
                            else if (stat.geom_zero)
                                state_next = ST_DH;
                            else
                                state_next = ST_DIV1_START;
                        end
                    OP_STATUS:
                    begin
                        case (phase_reg)
                            PH_READY:
                                if (stat.poll_gt_ready)
                                begin
                                    code_next  = CC_READY_TIMEOUT;
                                    phase_next = PH_IDLE;
                                    state_next = ST_DONE;
                                end
                                else if (stat.ready)
                                begin
                                    phase_next = PH_FIRST;
                                    state_next = ST_CMD;
                                end
                                else
                                begin
                                    dec_inc_poll = 1'b1;
                                    state_next   = ST_REQ_STAT;
                                end
                            PH_FIRST:
                                if (stat.busy)
                                begin
                                    dec_clr_poll = 1'b1;
                                    phase_next   = PH_BUSY;
                                    state_next   = ST_REQ_STAT;
                                end
                            PH_BUSY:
                                if (stat.poll_gt_busy)
                                begin
                                    code_next  = CC_BUSY_TIMEOUT;
                                    phase_next = PH_IDLE;
                                    state_next = ST_DONE;
                                end
                                else if (stat.busy)
                                begin
                                    dec_inc_poll = 1'b1;
                                    state_next   = ST_REQ_STAT;
                                end
                            PH_DSTAT:
                                if (stat.err)
                                begin
                                    code_next  = CC_DEVICE_ERROR;
                                    phase_next = PH_IDLE;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    dec_inc_word = 1'b1;
                                    ab_word_full = stat.word_next_full;
                                    if (stat.word_over)
                                    begin
                                        code_next  = CC_OVERRUN;
                                        phase_next = PH_IDLE;
                                        state_next = ST_DONE;
                                    end
                                end
                            default: ;
                        endcase
                        // end of busy wait or good data status: data request, end of sector or retry
                        if (((phase_reg == PH_FIRST) && !stat.busy) ||
                            ((phase_reg == PH_BUSY) && !stat.poll_gt_busy && !stat.busy) ||
                            ((phase_reg == PH_DSTAT) && !stat.err && !stat.word_over))
                        begin
                            if (stat.drq)
                            begin
                                phase_next = PH_DATA;
                                state_next = ST_REQ_DATA;
                            end
                            else if (ab_word_full)
                            begin
                                code_next  = CC_OK;
                                phase_next = PH_IDLE;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                dec_inc_retry = 1'b1;
                                if (stat.retry_next_full)
                                begin
                                    code_next  = CC_RETRIES;
                                    phase_next = PH_IDLE;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    dec_clr_word = 1'b1;
                                    phase_next   = PH_FIRST;
                                    state_next   = ST_REQ_STAT;
                                end
                            end
                        end
                    end
                    OP_DATA:
                        if (phase_reg == PH_DATA)
                        begin
                            phase_next = PH_DSTAT;
                            state_next = ST_WORD;
                        end
                    default: ;
                endcase
            end
            ST_DIV1_START: state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT:
                if (stat.div_done)
                    state_next = ST_DIV2_START;
            ST_DIV2_START: state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT:
                if (stat.div_done)
                    state_next = ST_SEC;
            ST_SEC:      if (stat.out_free) state_next = ST_CYLL;
            ST_CYLL:     if (stat.out_free) state_next = ST_CYLH;
            ST_CYLH:     if (stat.out_free) state_next = ST_DH;
            ST_DH:       if (stat.out_free) state_next = ST_CNT;
            ST_CNT:      if (stat.out_free) state_next = ST_REQ_STAT;
            ST_CMD:      if (stat.out_free) state_next = ST_REQ_STAT;
            ST_WORD:     if (stat.out_free) state_next = ST_REQ_STAT;
            ST_REQ_STAT: if (stat.out_free) state_next = ST_IDLE;
            ST_REQ_DATA: if (stat.out_free) state_next = ST_IDLE;
            ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.emit       = EM_NONE;
        cmd.code       = code_reg;
        cmd.take       = (state_reg == ST_IDLE) && in_valid;
        cmd.load_start = dec_load_start;
        cmd.load_lba   = dec_load_lba;
        cmd.clr_poll   = dec_clr_poll;
        cmd.inc_poll   = dec_inc_poll;
        cmd.clr_word   = dec_clr_word;
        cmd.inc_word   = dec_inc_word;
        cmd.inc_retry  = dec_inc_retry;
        in_stall       = state_reg != ST_IDLE;
        case (state_reg)
            ST_DIV1_START: cmd.div_start = 1'b1;
            ST_DIV1_WAIT:  cmd.div1_latch = stat.div_done;
            ST_DIV2_START:
            begin
                cmd.div_start  = 1'b1;
                cmd.div_second = 1'b1;
            end
            ST_DIV2_WAIT:
            begin
                cmd.div_second = 1'b1;
                cmd.div2_latch = stat.div_done;
            end
            ST_SEC:      cmd.emit = EM_SEC;
            ST_CYLL:     cmd.emit = EM_CYLL;
            ST_CYLH:     cmd.emit = EM_CYLH;
            ST_DH:       cmd.emit = EM_DH;
            ST_CNT:      cmd.emit = EM_CNT;
            ST_CMD:      cmd.emit = EM_CMD;
            ST_WORD:     cmd.emit = EM_WORD;
            ST_REQ_STAT: cmd.emit = EM_REQ_STAT;
            ST_REQ_DATA: cmd.emit = EM_REQ_DATA;
            ST_DONE:     cmd.emit = EM_DONE;
            default: ;
        endcase
        cmd.emit_en = (cmd.emit != EM_NONE) && stat.out_free;
    end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the ata pio sector read sequencer: drives start, status and data words,
// predicts every bus access and completion, and compares each result word field by field
// depends on ata_psr_pkg and ata_pio_sector_read_sequencer_top
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ata_psr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 100;

    logic      clk;
    logic      rst_n;
    logic      cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    ata_pio_sector_read_sequencer_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    // shadow of the sequencer
    bit          lba_on;
    bit          drive_bit;
    int unsigned heads;
    int unsigned spt;
    phase_t      ph;
    int unsigned polls;
    int unsigned words;
    int unsigned retries;
    logic [7:0]  held_cmd;
    logic [3:0]  head_nib;

    out_item_t bus_expected[$];
    int        errors;
    int        cycles;
    int        send_idle;
    int        recv_idle;
    bit        hold_off_req;

    in_item_t  dir_items[$];
    bit        dir_chk[$];
    out_item_t dir_last[$];

    function automatic void emit(logic [1:0] kind, logic [2:0] off, logic [15:0] val,
                                 logic [2:0] code);
        out_item_t r;
        r.result_kind     = kind;
        r.register_offset = off;
        r.write_value     = val;
        r.completion_code = code;
        r.last_of_run     = 1'b0;
        bus_expected.push_back(r);
    endfunction

    function automatic void complete(logic [2:0] code);
        ph = PH_IDLE;
        emit(KIND_DONE, REG_DATA, 16'h0, code);
    endfunction

    function automatic void poll_status(phase_t next);
        ph = next;
        emit(KIND_READ, REG_STATUS_CMD, 16'h0, CC_OK);
    endfunction

    function automatic void sector_end();
        if (words >= SECTOR_WORDS)
            complete(CC_OK);
        else
        begin
            retries = (retries + 1) & 8'hFF;
            if (retries >= RETRY_LIMIT)
                complete(CC_RETRIES);
            else
            begin
                words = 0;
                poll_status(PH_FIRST);
            end
        end
    endfunction

    function automatic void busy_cleared(bit drq);
        if (drq)
        begin
            ph = PH_DATA;
            emit(KIND_READ, REG_DATA, 16'h0, CC_OK);
        end
        else
            sector_end();
    endfunction

    function automatic void load_task_file(logic [27:0] lba, logic [7:0] cmd);
        int unsigned dv;
        int unsigned cyl;
        int unsigned rem;
        logic [7:0]  dh;
        if (lba_on)
        begin
            emit(KIND_WRITE, REG_SECTOR, {8'h0, lba[7:0]}, CC_OK);
            emit(KIND_WRITE, REG_CYL_LO, {8'h0, lba[15:8]}, CC_OK);
            emit(KIND_WRITE, REG_CYL_HI, {8'h0, lba[23:16]}, CC_OK);
            head_nib = lba[27:24];
        end
        else
        begin
            dv = heads * spt;
            if (dv != 0)
            begin
                cyl = (lba / dv) & 16'hFFFF;
                rem = lba % dv;
                head_nib = 4'((rem / spt) & 4'hF);
                emit(KIND_WRITE, REG_SECTOR, 16'(((rem % spt) + 1) & 8'hFF), CC_OK);
                emit(KIND_WRITE, REG_CYL_LO, 16'(cyl & 8'hFF), CC_OK);
                emit(KIND_WRITE, REG_CYL_HI, 16'((cyl >> 8) & 8'hFF), CC_OK);
            end
        end
        dh = 8'hA0 | (drive_bit ? 8'h10 : 8'h00) | (lba_on ? 8'h40 : 8'h00) | head_nib;
        emit(KIND_WRITE, REG_DRIVE_HEAD, {8'h0, dh}, CC_OK);
        emit(KIND_WRITE, REG_COUNT, 16'h1, CC_OK);
        held_cmd = cmd;
        polls    = 0;
        words    = 0;
        retries  = 0;
        poll_status(PH_READY);
    endfunction

    // returns the number of result words this input word causes
    function automatic int sequence_step(in_item_t it);
        int n0;
        n0 = bus_expected.size();
        if (it.opcode == OP_START)
        begin
            if (ph == PH_IDLE)
                load_task_file(it.block_address, it.command_code);
        end
        else if (it.opcode == OP_STATUS)
        begin
            case (ph)
                PH_READY:
                    if (polls > READY_POLL_LIMIT)
                        complete(CC_READY_TIMEOUT);
                    else if (it.status_ready)
                    begin
                        emit(KIND_WRITE, REG_STATUS_CMD, {8'h0, held_cmd}, CC_OK);
                        poll_status(PH_FIRST);
                    end
                    else
                    begin
                        polls++;
                        poll_status(PH_READY);
                    end
                PH_FIRST:
                    if (it.status_busy)
                    begin
                        polls = 0;
                        poll_status(PH_BUSY);
                    end
                    else
                        busy_cleared(it.status_drq);
                PH_BUSY:
                    if (polls > BUSY_POLL_LIMIT)
                        complete(CC_BUSY_TIMEOUT);
                    else if (it.status_busy)
                    begin
                        polls++;
                        poll_status(PH_BUSY);
                    end
                    else
                        busy_cleared(it.status_drq);
                PH_DSTAT:
                    if (it.status_error)
                        complete(CC_DEVICE_ERROR);
                    else
                    begin
                        words++;
                        if (words > SECTOR_WORDS)
                            complete(CC_OVERRUN);
                        else
                            busy_cleared(it.status_drq);
                    end
                default:
                    ;
            endcase
        end
        else if (it.opcode == OP_DATA)
        begin
            if (ph == PH_DATA)
            begin
                emit(KIND_WORD, REG_DATA, it.read_word, CC_OK);
                poll_status(PH_DSTAT);
            end
        end
        if (bus_expected.size() > n0)
            bus_expected[bus_expected.size() - 1].last_of_run = 1'b1;
        return bus_expected.size() - n0;
    endfunction

    function automatic in_item_t start_word(logic [27:0] lba, logic [7:0] cmd);
        in_item_t it;
        it = '0;
        it.opcode        = OP_START;
        it.block_address = lba;
        it.command_code  = cmd;
        return it;
    endfunction

    function automatic in_item_t status_word(bit b, bit r, bit d, bit e);
        in_item_t it;
        it = '0;
        it.opcode       = OP_STATUS;
        it.status_busy  = b;
        it.status_ready = r;
        it.status_drq   = d;
        it.status_error = e;
        return it;
    endfunction

    function automatic in_item_t data_word(logic [15:0] w);
        in_item_t it;
        it = '0;
        it.opcode    = OP_DATA;
        it.read_word = w;
        return it;
    endfunction

    function automatic out_item_t result_word(logic [1:0] kind, logic [2:0] off,
                                              logic [15:0] val, logic [2:0] code);
        out_item_t r;
        r.result_kind     = kind;
        r.register_offset = off;
        r.write_value     = val;
        r.completion_code = code;
        r.last_of_run     = 1'b1;
        return r;
    endfunction

    // picks a fitting word for the current phase, with some raw random words
    function automatic in_item_t next_word();
        in_item_t    it;
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(99) < 8)
        begin
            it = raw[$bits(in_item_t)-1:0];
            return it;
        end
        case (ph)
            PH_IDLE:
                it = start_word(28'($urandom()), 8'($urandom()));
            PH_READY:
                it = status_word(1'($urandom_range(1)), $urandom_range(99) < 70,
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
            PH_FIRST, PH_BUSY:
                it = status_word($urandom_range(99) < 40, 1'($urandom_range(1)),
                                 $urandom_range(99) < 90, 1'($urandom_range(1)));
            PH_DATA:
                it = data_word(16'($urandom()));
            PH_DSTAT:
                it = status_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 $urandom_range(99) < 93, $urandom_range(99) < 3);
            default:
                it = '0;
        endcase
        it.read_word = 16'($urandom());
        return it;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
        errors++;
    endtask

    task automatic send_word(in_item_t it, output int produced);
        @(negedge clk);
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        produced = sequence_step(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_LBA_MODE:     lba_on    = val[0];
            CFG_DRIVE_SELECT: drive_bit = val[0];
            CFG_HEAD_COUNT:   heads     = val[4:0];
            CFG_SPT:          spt       = val;
            default:          ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_geometry(bit lba, bit drv, logic [7:0] h, logic [7:0] s);
        write_reg(CFG_LBA_MODE, {7'd0, lba});
        write_reg(CFG_DRIVE_SELECT, {7'd0, drv});
        write_reg(CFG_HEAD_COUNT, h);
        write_reg(CFG_SPT, s);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bus_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_random(int count, int s_idle, int r_idle);
        int n;
        int done;
        done = 0;
        send_idle = s_idle;
        recv_idle = r_idle;
        while (done < count)
        begin
            if (done == count / 2 && r_idle == 0)
                hold_off_req = 1'b1;
            send_word(next_word(), n);
            if (n > 0)
                done++;
        end
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side: random stall, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= (recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bus_expected.size() == 0)
                report("unexpected word, kind", out_item.result_kind, 0);
            else
            begin
                want = bus_expected.pop_front();
                if (out_item.result_kind !== want.result_kind)
                    report("result_kind", out_item.result_kind, want.result_kind);
                if (out_item.register_offset !== want.register_offset)
                    report("register_offset", out_item.register_offset, want.register_offset);
                if (out_item.write_value !== want.write_value)
                    report("write_value", out_item.write_value, want.write_value);
                if (out_item.completion_code !== want.completion_code)
                    report("completion_code", out_item.completion_code, want.completion_code);
                if (out_item.last_of_run !== want.last_of_run)
                    report("last_of_run", out_item.last_of_run, want.last_of_run);
            end
        end
    end

    initial
    begin
        int n;
        errors       = 0;
        cycles       = 0;
        send_idle    = 0;
        recv_idle    = 0;
        hold_off_req = 1'b0;
        lba_on       = 1'b0;
        drive_bit    = 1'b0;
        heads        = 0;
        spt          = 0;
        ph           = PH_IDLE;
        polls        = 0;
        words        = 0;
        retries      = 0;
        held_cmd     = '0;
        head_nib     = '0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_item      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero geometry after reset: address writes skipped
        dir_items = '{start_word(28'hFFFFFFF, 8'h20), start_word(28'h0, 8'hFF),
                      status_word(1'b1, 1'b0, 1'b1, 1'b1), status_word(1'b0, 1'b1, 1'b0, 1'b0),
                      status_word(1'b1, 1'b0, 1'b0, 1'b0), status_word(1'b0, 1'b0, 1'b1, 1'b0),
                      data_word(16'hFFFF), status_word(1'b0, 1'b0, 1'b0, 1'b0),
                      status_word(1'b0, 1'b0, 1'b1, 1'b0), data_word(16'h0000),
                      status_word(1'b0, 1'b0, 1'b1, 1'b1), {2'd3, 28'hFFFFFFF, 8'hFF, 20'hFFFFF},
                      data_word(16'h1234), status_word(1'b1, 1'b1, 1'b1, 1'b1)};
        dir_chk   = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0};
        dir_last  = '{result_word(KIND_READ, REG_STATUS_CMD, 16'h0, CC_OK), '0, '0, '0, '0,
                      result_word(KIND_READ, REG_DATA, 16'h0, CC_OK), '0, '0, '0, '0,
                      result_word(KIND_DONE, REG_DATA, 16'h0, CC_DEVICE_ERROR), '0, '0, '0};
        foreach (dir_items[i])
        begin
            send_word(dir_items[i], n);
            if (dir_chk[i] && n > 0)
                bus_expected[bus_expected.size() - 1] = dir_last[i];
        end
        drain();

        set_geometry(1'b0, 1'b1, 8'd16, 8'd255);
        run_random(50, 21, 52);
        set_geometry(1'b1, 1'b0, 8'd1, 8'd1);
        run_random(50, 52, 21);
        set_geometry(1'b0, 1'b1, 8'd1, 8'd1);
        run_random(25, 0, 0);
        set_geometry(1'b0, 1'b0, 8'($urandom_range(16)), 8'($urandom_range(255)));
        run_random(25, 0, 0);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
